>>> rtl/core/brfs_pkg.sv
package brfs_pkg;

   localparam int MAX_SLOTS_DEF = 256;

   localparam int MODE_W = 3;
   localparam int DATA_W = 8;
   localparam int POS_W  = 8;
   localparam int FILL_W = 8;
   localparam int SIZE_W = 9;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index, taken from the word address bit of paddr.
   localparam logic CSR_IDX_SIZE = 1'b0;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH  = 3'd0,
      MODE_POP   = 3'd1,
      MODE_PEEK  = 3'd2,
      MODE_FIND  = 3'd3,
      MODE_CLEAR = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_FIND_RD,
      ST_FIND_CMP,
      ST_WB
   } state_type;

   typedef struct packed {
      logic start;
      logic rd_en;
      logic rd_scan;
      logic take_read;
      logic scan_next;
      logic found_hit;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic empty;
      logic match;
      logic last;
      logic rsp_free;
   } ctl_sts_type;

endpackage

>>> rtl/core/brfs_req_if.sv
interface brfs_req_if;
   import brfs_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [DATA_W-1:0] data_in;

   modport source (output valid, output mode, output data_in, input ready);
   modport sink (input valid, input mode, input data_in, output ready);
endinterface

>>> rtl/core/brfs_rsp_if.sv
interface brfs_rsp_if;
   import brfs_pkg::*;

   logic              valid;
   logic              ready;
   logic              accepted;
   logic [DATA_W-1:0] data_out;
   logic              found;
   logic [POS_W-1:0]  position;
   logic [FILL_W-1:0] fill_level;
   logic              is_empty;

   modport source (
      output valid, output accepted, output data_out, output found,
      output position, output fill_level, output is_empty, input ready
   );
   modport sink (
      input valid, input accepted, input data_out, input found,
      input position, input fill_level, input is_empty, output ready
   );
endinterface

>>> rtl/core/brfs_ctrl.sv
module brfs_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [brfs_pkg::MODE_W-1:0]    req_mode,
   output logic                           req_ready,
   input  brfs_pkg::ctl_sts_type          sts,
   output brfs_pkg::ctl_cmd_type          cmd
);
   import brfs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               unique case (mode_type'(req_mode))
                  MODE_POP, MODE_PEEK: begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_READ;
                  end
                  MODE_FIND: begin
                     state_in = sts.empty ? ST_WB : ST_FIND_RD;
                  end
                  default: begin
                     state_in = ST_WB;
                  end
               endcase
            end
         end
         ST_READ: begin
            cmd.take_read = 1'b1;
            state_in      = ST_WB;
         end
         ST_FIND_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_scan = 1'b1;
            state_in    = ST_FIND_CMP;
         end
         ST_FIND_CMP: begin
            priority if (sts.match) begin
               cmd.found_hit = 1'b1;
               state_in      = ST_WB;
            end else if (sts.last) begin
               state_in = ST_WB;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = ST_FIND_RD;
            end
         end
         ST_WB: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_hit_goes_to_wb: assert property (@(posedge clock) disable iff (reset)
      cmd.found_hit |=> state_ff == ST_WB)
      else $error("match did not lead to the result stage");

   a_start_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> state_ff != ST_IDLE)
      else $error("accepted request left the controller idle");

   a_scan_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_next |-> $past(cmd.rd_scan))
      else $error("scan stepped without a preceding read");
endmodule

>>> rtl/core/brfs_datapath.sv
module brfs_datapath #(
   parameter int MAX_SLOTS = brfs_pkg::MAX_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  brfs_pkg::ctl_cmd_type             cmd,
   output brfs_pkg::ctl_sts_type             sts,
   input  logic [brfs_pkg::MODE_W-1:0]       req_mode,
   input  logic [brfs_pkg::DATA_W-1:0]       req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_accepted,
   output logic [brfs_pkg::DATA_W-1:0]       rsp_data,
   output logic                              rsp_found,
   output logic [brfs_pkg::POS_W-1:0]        rsp_position,
   output logic [brfs_pkg::FILL_W-1:0]       rsp_fill,
   output logic                              rsp_empty,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [brfs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [brfs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [brfs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import brfs_pkg::*;

   localparam int PW = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;
   localparam int SW = $clog2(MAX_SLOTS + 1);
   localparam int CW = (SW > SIZE_W) ? SW : SIZE_W;

   function automatic logic [SW-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      logic [CW-1:0] ve;
      ve = CW'(v);
      if (ve < CW'(2)) begin
         return SW'(2);
      end else if (ve > CW'(MAX_SLOTS)) begin
         return SW'(MAX_SLOTS);
      end
      return SW'(ve);
   endfunction

   function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [SW-1:0] s);
      logic [SW-1:0] nxt;
      nxt = SW'(p) + SW'(1);
      return (nxt == s) ? '0 : PW'(nxt);
   endfunction

   logic [DATA_W-1:0] mem [MAX_SLOTS];

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SW-1:0]     slots_ff, slots_in;
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [PW-1:0]     scan_ptr_ff, scan_ptr_in;
   logic [PW-1:0]     scan_cnt_ff, scan_cnt_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic              acc_ff, acc_in;
   logic [DATA_W-1:0] dout_ff, dout_in;
   logic              found_ff, found_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] rd_data_ff;

   logic              rsp_acc_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic              rsp_found_ff;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic [FILL_W-1:0] rsp_fill_ff;
   logic              rsp_empty_ff;

   logic [SW-1:0]     held;
   logic              full;
   logic              empty;
   logic              csr_wr;
   logic              mem_we;
   logic [PW-1:0]     rd_addr;

   assign held  = (wr_ptr_ff >= rd_ptr_ff) ? SW'(wr_ptr_ff) - SW'(rd_ptr_ff)
                                           : slots_ff - SW'(rd_ptr_ff) + SW'(wr_ptr_ff);
   assign full  = (held == slots_ff - SW'(1));
   assign empty = (held == '0);

   assign csr_wr  = psel && penable && pwrite && (paddr[2] == CSR_IDX_SIZE);
   assign pready  = 1'b1;
   assign prdata  = (paddr[2] == CSR_IDX_SIZE) ? CSR_DATA_W'(size_ff) : '0;

   assign mem_we  = cmd.start && !csr_wr && (req_mode == MODE_PUSH) && !full;
   assign rd_addr = cmd.rd_scan ? scan_ptr_ff : rd_ptr_ff;

   assign sts.empty    = empty;
   assign sts.match    = (rd_data_ff == key_ff);
   assign sts.last     = (SW'(scan_cnt_ff) + SW'(1) == held);
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      size_in     = size_ff;
      slots_in    = slots_ff;
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      scan_ptr_in = scan_ptr_ff;
      scan_cnt_in = scan_cnt_ff;
      mode_in     = mode_ff;
      key_in      = key_ff;
      acc_in      = acc_ff;
      dout_in     = dout_ff;
      found_in    = found_ff;
      pos_in      = pos_ff;
      if (csr_wr) begin
         size_in   = pwdata[SIZE_W-1:0];
         slots_in  = clamp_size(pwdata[SIZE_W-1:0]);
         wr_ptr_in = '0;
         rd_ptr_in = '0;
      end else begin
         if (cmd.start) begin
            mode_in  = req_mode;
            key_in   = req_data;
            acc_in   = 1'b0;
            dout_in  = '0;
            found_in = 1'b0;
            pos_in   = '0;
            unique case (mode_type'(req_mode))
               MODE_PUSH: begin
                  if (!full) begin
                     wr_ptr_in = adv(wr_ptr_ff, slots_ff);
                     acc_in    = 1'b1;
                  end
               end
               MODE_POP, MODE_PEEK: begin
                  acc_in = !empty;
               end
               MODE_FIND: begin
                  scan_ptr_in = rd_ptr_ff;
                  scan_cnt_in = '0;
               end
               MODE_CLEAR: begin
                  wr_ptr_in = '0;
                  rd_ptr_in = '0;
               end
               default: begin
               end
            endcase
         end
         if (cmd.take_read && acc_ff) begin
            dout_in = rd_data_ff;
            if (mode_ff == MODE_POP) begin
               rd_ptr_in = adv(rd_ptr_ff, slots_ff);
            end
         end
         if (cmd.scan_next) begin
            scan_ptr_in = adv(scan_ptr_ff, slots_ff);
            scan_cnt_in = scan_cnt_ff + PW'(1);
         end
         if (cmd.found_hit) begin
            found_in = 1'b1;
            pos_in   = POS_W'(scan_cnt_ff);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_RESET;
         slots_ff     <= clamp_size(SIZE_RESET);
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         slots_ff     <= slots_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      scan_cnt_ff <= scan_cnt_in;
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      acc_ff      <= acc_in;
      dout_ff     <= dout_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      if (cmd.load_rsp) begin
         rsp_acc_ff   <= acc_ff;
         rsp_data_ff  <= dout_ff;
         rsp_found_ff <= found_ff;
         rsp_pos_ff   <= pos_ff;
         rsp_fill_ff  <= FILL_W'(held);
         rsp_empty_ff <= empty;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ptr_ff] <= req_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_acc_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_fill     = rsp_fill_ff;
   assign rsp_empty    = rsp_empty_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      held < slots_ff)
      else $error("fill level reached the slot count");

   a_ptrs_in_range: assert property (@(posedge clock) disable iff (reset)
      SW'(wr_ptr_ff) < slots_ff && SW'(rd_ptr_ff) < slots_ff)
      else $error("pointer outside the active slots");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> held == $past(held) + SW'(1))
      else $error("stored push did not raise the fill level");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> sts.rsp_free)
      else $error("result register overwritten while still held");
endmodule

>>> rtl/core/byte_ring_fifo_with_search.sv
// Byte ring buffer with one slot kept free, so it holds at most buffer_size-1 bytes
// (buffer_size is clamped to 2..MAX_SLOTS; writing it empties the buffer). One request
// is processed at a time. A push, clear or unused mode goes from idle to write-back, a
// pop or peek first passes a read state as the byte store has a registered read port, and
// a find passes a read and a compare state per byte examined until a match or the end of
// the held data, one byte per read and compare on the single store read port. A new
// request is taken while the previous response still waits in the output register.
// The byte store is not cleared after reset; only written entries ever reach a response.
module byte_ring_fifo_with_search #(
   parameter int MAX_SLOTS = brfs_pkg::MAX_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   brfs_req_if.sink                          req_ch,
   brfs_rsp_if.source                        rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [brfs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [brfs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [brfs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import brfs_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   brfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   brfs_datapath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_mode     (req_ch.mode),
      .req_data     (req_ch.data_in),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_accepted (rsp_ch.accepted),
      .rsp_data     (rsp_ch.data_out),
      .rsp_found    (rsp_ch.found),
      .rsp_position (rsp_ch.position),
      .rsp_fill     (rsp_ch.fill_level),
      .rsp_empty    (rsp_ch.is_empty),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );
endmodule
